[hdl/spmm_pkg.sv]
// Package for the split pointer motion mixer.
// Register index codes and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package spmm_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_IS_MAIN_HALF  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_MAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_REMOTE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_MAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_REMOTE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HORIZ_DIVISOR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VERT_DIVISOR  = 3'd6;

  typedef struct packed {
    logic load_in;
    logic start_h;
    logic start_v;
    logic commit_h;
    logic commit_v;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic scroll_en;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[hdl/split_pointer_motion_mixer_top.sv]
// Split pointer motion mixer, top level: controller plus datapath.
// Without scrolling a captured word goes straight to the output register; with scrolling,
// the two 8-step passes of the shared bit-serial divider (horizontal, then vertical) come
//   between. A new word is accepted only after the previous one is loaded for output.
// The next word is accepted while a finished word waits in the output register.
// Synchronous reset loads register defaults and clears both scroll remainders.
`default_nettype none

module split_pointer_motion_mixer_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [spmm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [spmm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [7:0]               local_dx,
  input  wire logic signed [7:0]               local_dy,
  input  wire logic signed [6:0]               remote_dx,
  input  wire logic signed [6:0]               remote_dy,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [9:0]                    move_x,
  output logic signed [9:0]                    move_y,
  output logic signed [7:0]                    scroll_h,
  output logic signed [7:0]                    scroll_v
);
  import spmm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  spmm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  spmm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .local_dx  (local_dx),
    .local_dy  (local_dy),
    .remote_dx (remote_dx),
    .remote_dy (remote_dy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .move_x    (move_x),
    .move_y    (move_y),
    .scroll_h  (scroll_h),
    .scroll_v  (scroll_v),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

[hdl/spmm_div.sv]
// Iterative signed divider, 8-bit dividend by 7-bit nonzero divisor, one bit per cycle.
// Truncates toward zero; remainder takes the dividend's sign. No dependencies.
`default_nettype none

module spmm_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic signed [7:0] dividend,
  input  wire logic        [6:0] divisor,
  output logic                   done,
  output logic signed [8:0]      quotient,
  output logic signed [7:0]      remainder
);

  logic       busy;
  logic [2:0] cnt;
  logic [7:0] r;
  logic [7:0] qd;
  logic [6:0] dvs;
  logic       neg;
  logic [7:0] trial;
  logic [7:0] diff;
  logic       fits;
  logic [8:0] qmag;

  assign trial = {r[6:0], qd[7]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r   <= '0;
      qd  <= dividend[7] ? 8'(-dividend) : 8'(dividend);
      dvs <= divisor;
      neg <= dividend[7];
    end else if (busy) begin
      r  <= fits ? diff : trial;
      qd <= {qd[6:0], fits};
    end
  end

  assign qmag      = {1'b0, qd};
  assign quotient  = neg ? -$signed(qmag) : $signed(qmag);
  assign remainder = neg ? -$signed(r) : $signed(r);

endmodule

`default_nettype wire

[hdl/spmm_ctrl.sv]
// Controller state machine for the split pointer motion mixer.
// Sequences capture, the two scroll divisions and the output load. Uses spmm_pkg.
`default_nettype none

module spmm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire spmm_pkg::sts_t sts,
  output spmm_pkg::cmd_t     cmd
);
  import spmm_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ROUTE  = 3'd1;
  localparam logic [2:0] S_HWAIT  = 3'd2;
  localparam logic [2:0] S_VSTART = 3'd3;
  localparam logic [2:0] S_VWAIT  = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_ROUTE;
        end
      end
      S_ROUTE: begin
        if (sts.scroll_en) begin
          cmd.start_h = 1'b1;
          state_next  = S_HWAIT;
        end else begin
          state_next = S_OUT;
        end
      end
      S_HWAIT: begin
        if (sts.div_done) begin
          cmd.commit_h = 1'b1;
          state_next   = S_VSTART;
        end
      end
      S_VSTART: begin
        cmd.start_v = 1'b1;
        state_next  = S_VWAIT;
      end
      S_VWAIT: begin
        if (sts.div_done) begin
          cmd.commit_v = 1'b1;
          state_next   = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[hdl/spmm_dp.sv]
// Datapath for the split pointer motion mixer: config registers, input capture,
// routing, gain, scroll accumulators and output word register. Uses spmm_pkg, spmm_div.
`default_nettype none

module spmm_dp (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [spmm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [spmm_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic signed [7:0]                  local_dx,
  input  wire logic signed [7:0]                  local_dy,
  input  wire logic signed [6:0]                  remote_dx,
  input  wire logic signed [6:0]                  remote_dy,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [9:0]                       move_x,
  output logic signed [9:0]                       move_y,
  output logic signed [7:0]                       scroll_h,
  output logic signed [7:0]                       scroll_v,
  input  wire spmm_pkg::cmd_t                     cmd,
  output spmm_pkg::sts_t                          sts
);
  import spmm_pkg::*;

  // truncating divide by 3 via reciprocal 171/512, exact for |d| <= 128
  function automatic logic signed [6:0] div3(input logic signed [7:0] d);
    logic [7:0]  mag;
    logic [15:0] prod;
    logic [6:0]  q;
    mag  = d[7] ? 8'(-d) : 8'(d);
    prod = {8'd0, mag} * 16'd171;
    q    = prod[15:9];
    return d[7] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [9:0] gain_scale(input logic signed [6:0] d,
                                                   input logic [2:0] g);
    logic [6:0]         mag;
    logic [2:0]         ge;
    logic signed [10:0] p;
    mag = d[6] ? 7'(-d) : 7'(d);
    if (g > 3'd2 && mag < 7'd2) begin
      ge = 3'd3;
    end else if (g > 3'd2 && mag < 7'd5) begin
      ge = 3'd4;
    end else begin
      ge = g;
    end
    p = $signed({{4{d[6]}}, d}) * $signed({8'd0, ge});
    return p[9:0];
  endfunction

  logic       is_main_half;
  logic [2:0] gain_main;
  logic [2:0] gain_remote;
  logic       scroll_main;
  logic       scroll_remote;
  logic [6:0] horiz_divisor;
  logic [6:0] vert_divisor;

  logic signed [7:0] horiz_rem;
  logic signed [7:0] vert_rem;
  logic signed [6:0] lx, ly, rx, ry;
  logic signed [8:0] qh, qv;

  logic              local_idle;
  logic              move_local, move_remote, scroll_local, scroll_remote_src;
  logic signed [6:0] hd, vd;
  logic signed [7:0] sum_h, sum_v;
  logic [6:0]        hdiv_eff, vdiv_eff;
  logic              div_start;
  logic signed [7:0] div_dividend;
  logic [6:0]        div_divisor;
  logic              div_done;
  logic signed [8:0] div_q;
  logic signed [7:0] div_r;
  logic signed [9:0] mx, my;
  logic signed [8:0] neg_qh;
  logic              out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      is_main_half  <= 1'b1;
      gain_main     <= 3'd2;
      gain_remote   <= 3'd2;
      scroll_main   <= 1'b0;
      scroll_remote <= 1'b0;
      horiz_divisor <= 7'd10;
      vert_divisor  <= 7'd20;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IS_MAIN_HALF:  is_main_half  <= cfg_data[0];
        REG_GAIN_MAIN:     gain_main     <= cfg_data[2:0];
        REG_GAIN_REMOTE:   gain_remote   <= cfg_data[2:0];
        REG_SCROLL_MAIN:   scroll_main   <= cfg_data[0];
        REG_SCROLL_REMOTE: scroll_remote <= cfg_data[0];
        REG_HORIZ_DIVISOR: horiz_divisor <= cfg_data;
        REG_VERT_DIVISOR:  vert_divisor  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      lx <= div3(local_dx);
      ly <= div3(local_dy);
      rx <= remote_dx;
      ry <= remote_dy;
    end
  end

  // routing
  assign local_idle = (lx == 7'sd0) && (ly == 7'sd0);
  assign move_local = (!scroll_main && !scroll_remote && !local_idle)
                    || (!scroll_main && scroll_remote);
  assign move_remote = (!scroll_main && !scroll_remote && local_idle)
                     || (scroll_main && !scroll_remote);
  assign scroll_local = (scroll_main && scroll_remote && !local_idle)
                      || (scroll_main && !scroll_remote);
  assign scroll_remote_src = (scroll_main && scroll_remote && local_idle)
                           || (!scroll_main && scroll_remote);

  assign hd = scroll_local ? lx : rx;
  assign vd = scroll_local ? ly : ry;
  assign sum_h = horiz_rem + {hd[6], hd};
  assign sum_v = vert_rem + {vd[6], vd};
  assign hdiv_eff = (horiz_divisor == 7'd0) ? 7'd1 : horiz_divisor;
  assign vdiv_eff = (vert_divisor == 7'd0) ? 7'd1 : vert_divisor;

  assign div_start    = cmd.start_h || cmd.start_v;
  assign div_dividend = cmd.start_v ? sum_v : sum_h;
  assign div_divisor  = cmd.start_v ? vdiv_eff : hdiv_eff;

  spmm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      horiz_rem <= '0;
      vert_rem  <= '0;
    end else if (cfg_we && (cfg_index == REG_SCROLL_MAIN
                            || cfg_index == REG_SCROLL_REMOTE)) begin
      horiz_rem <= '0;
      vert_rem  <= '0;
    end else if (cmd.commit_h) begin
      horiz_rem <= div_r;
      if (div_q != 9'sd0) begin
        vert_rem <= '0;
      end
    end else if (cmd.commit_v) begin
      vert_rem <= div_r;
      if (div_q != 9'sd0) begin
        horiz_rem <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_h) begin
      qh <= div_q;
    end
    if (cmd.commit_v) begin
      qv <= div_q;
    end
  end

  always_comb begin
    if (!is_main_half) begin
      mx = {{3{lx[6]}}, lx};
      my = -$signed({{3{ly[6]}}, ly});
    end else if (move_local) begin
      mx = -gain_scale(lx, gain_main);
      my = -gain_scale(ly, gain_main);
    end else if (move_remote) begin
      mx = -gain_scale(rx, gain_remote);
      my = -gain_scale(ry, gain_remote);
    end else begin
      mx = '0;
      my = '0;
    end
  end

  assign neg_qh   = -qh;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      move_x <= mx;
      move_y <= my;
      if (sts.scroll_en) begin
        scroll_h <= neg_qh[7:0];
        scroll_v <= qv[7:0];
      end else begin
        scroll_h <= '0;
        scroll_v <= '0;
      end
    end
  end

  assign sts.scroll_en = is_main_half && (scroll_local || scroll_remote_src);
  assign sts.div_done  = div_done;
  assign sts.out_free  = out_free;

  a_load_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> out_free)
    else $error("output word loaded while the previous one is still held");

  a_h_clears_v: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit_h && div_q != 9'sd0 && !cfg_we) |=> (vert_rem == 8'sd0))
    else $error("horizontal step did not clear vertical remainder");

  a_v_clears_h: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit_v && div_q != 9'sd0 && !cfg_we) |=> (horiz_rem == 8'sd0))
    else $error("vertical step did not clear horizontal remainder");

endmodule

`default_nettype wire

[tb/tb_split_pointer_motion_mixer_top.sv]
// Testbench for split_pointer_motion_mixer_top: poll words in, motion reports out.
// A scoreboard class predicts each report from the accepted poll word.
// Depends on spmm_pkg and the top level only.
`timescale 1ns / 100ps

module tb_split_pointer_motion_mixer_top;
  import spmm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic signed [9:0] move_x;
    logic signed [9:0] move_y;
    logic signed [7:0] scroll_h;
    logic signed [7:0] scroll_v;
  } report_t;

  class motion_board;
    bit       main_half;
    bit [2:0] gain_loc;
    bit [2:0] gain_rem;
    bit       scroll_loc;
    bit       scroll_rem;
    bit [6:0] horiz_div;
    bit [6:0] vert_div;
    int       horiz_acc;
    int       vert_acc;
    report_t  pending_reports[$];
    int       errors;

    function new();
      main_half  = 1'b1;
      gain_loc   = 3'd2;
      gain_rem   = 3'd2;
      scroll_loc = 1'b0;
      scroll_rem = 1'b0;
      horiz_div  = 7'd10;
      vert_div   = 7'd20;
      horiz_acc  = 0;
      vert_acc   = 0;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_IS_MAIN_HALF: main_half = val[0];
        REG_GAIN_MAIN:    gain_loc  = val[2:0];
        REG_GAIN_REMOTE:  gain_rem  = val[2:0];
        REG_SCROLL_MAIN: begin
          scroll_loc = val[0];
          horiz_acc  = 0;
          vert_acc   = 0;
        end
        REG_SCROLL_REMOTE: begin
          scroll_rem = val[0];
          horiz_acc  = 0;
          vert_acc   = 0;
        end
        REG_HORIZ_DIVISOR: horiz_div = val;
        REG_VERT_DIVISOR:  vert_div  = val;
        default: ;
      endcase
    endfunction

    function int scaled(int d, int g);
      int mag;
      mag = (d < 0) ? -d : d;
      if (g > 2) begin
        if (mag < 2) return d * 3;
        if (mag < 5) return d * 4;
      end
      return d * g;
    endfunction

    function int wheel_step(inout int acc, input int d, input int div);
      int dv;
      int s;
      int q;
      dv  = (div == 0) ? 1 : div;
      s   = int'(byte'(acc + d));
      q   = s / dv;
      acc = s % dv;
      return q;
    endfunction

    function void scroll_pair(int hd, int vd, output int sh, output int sv);
      int qh;
      int qv;
      qh = wheel_step(horiz_acc, hd, int'(horiz_div));
      if (qh != 0) vert_acc = 0;
      qv = wheel_step(vert_acc, vd, int'(vert_div));
      if (qv != 0) horiz_acc = 0;
      sh = -qh;
      sv = qv;
    endfunction

    function void note_poll(logic signed [7:0] ldx, logic signed [7:0] ldy,
                            logic signed [6:0] rdx, logic signed [6:0] rdy);
      int      lx;
      int      ly;
      int      rx;
      int      ry;
      int      mx;
      int      my;
      int      sh;
      int      sv;
      bit      mv_l;
      bit      mv_r;
      bit      sc_l;
      bit      sc_r;
      report_t r;
      lx = int'(ldx) / 3;
      ly = int'(ldy) / 3;
      rx = int'(rdx);
      ry = int'(rdy);
      mx = 0;
      my = 0;
      sh = 0;
      sv = 0;
      mv_l = 0;
      mv_r = 0;
      sc_l = 0;
      sc_r = 0;
      if (!main_half) begin
        mx = lx;
        my = -ly;
      end else begin
        if (scroll_loc == scroll_rem) begin
          if (!scroll_loc) begin
            if (lx == 0 && ly == 0) mv_r = 1; else mv_l = 1;
          end else begin
            if (lx == 0 && ly == 0) sc_r = 1; else sc_l = 1;
          end
        end else if (!scroll_loc) begin
          mv_l = 1;
          sc_r = 1;
        end else begin
          mv_r = 1;
          sc_l = 1;
        end
        if (mv_l) begin
          mx = -scaled(lx, int'(gain_loc));
          my = -scaled(ly, int'(gain_loc));
        end else if (mv_r) begin
          mx = -scaled(rx, int'(gain_rem));
          my = -scaled(ry, int'(gain_rem));
        end
        if (sc_l) scroll_pair(lx, ly, sh, sv);
        else if (sc_r) scroll_pair(rx, ry, sh, sv);
      end
      r.move_x   = 10'(mx);
      r.move_y   = 10'(my);
      r.scroll_h = 8'(sh);
      r.scroll_v = 8'(sv);
      pending_reports.push_back(r);
    endfunction

    function void check_report(report_t got);
      report_t want;
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected report: got move %0d,%0d scroll %0d,%0d", $time,
                 got.move_x, got.move_y, got.scroll_h, got.scroll_v);
        return;
      end
      want = pending_reports.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: report mismatch: expected %0d,%0d,%0d,%0d got %0d,%0d,%0d,%0d",
                 $time, want.move_x, want.move_y, want.scroll_h, want.scroll_v,
                 got.move_x, got.move_y, got.scroll_h, got.scroll_v);
      end
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [7:0]       local_dx = '0;
  logic signed [7:0]       local_dy = '0;
  logic signed [6:0]       remote_dx = '0;
  logic signed [6:0]       remote_dy = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [9:0]       move_x;
  logic signed [9:0]       move_y;
  logic signed [7:0]       scroll_h;
  logic signed [7:0]       scroll_v;

  motion_board board;
  int          in_idle_pct = 14;
  int          out_idle_pct = 14;
  int unsigned cycle_count = 0;

  split_pointer_motion_mixer_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .local_dx  (local_dx),
    .local_dy  (local_dy),
    .remote_dx (remote_dx),
    .remote_dy (remote_dy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .move_x    (move_x),
    .move_y    (move_y),
    .scroll_h  (scroll_h),
    .scroll_v  (scroll_v)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  always @(negedge clk) begin
    out_ready <= rst ? 1'b0 : ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      board.check_report({move_x, move_y, scroll_h, scroll_v});
    end
  end

  task automatic send_poll(input logic signed [7:0] ldx, input logic signed [7:0] ldy,
                           input logic signed [6:0] rdx, input logic signed [6:0] rdy);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    local_dx  <= ldx;
    local_dy  <= ldy;
    remote_dx <= rdx;
    remote_dy <= rdy;
    do @(posedge clk); while (!in_ready);
    board.note_poll(ldx, ldy, rdx, rdy);
  endtask

  // hold the sender until every report is back and the block has gone quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    board.set_reg(idx, val);
  endtask

  task automatic apply_setting(input bit main_half, input bit [2:0] gm, input bit [2:0] gr,
                               input bit sm, input bit sr, input bit [6:0] hd,
                               input bit [6:0] vd);
    write_reg(REG_IS_MAIN_HALF, 7'(main_half));
    write_reg(REG_GAIN_MAIN, 7'(gm));
    write_reg(REG_GAIN_REMOTE, 7'(gr));
    write_reg(REG_SCROLL_MAIN, 7'(sm));
    write_reg(REG_SCROLL_REMOTE, 7'(sr));
    write_reg(REG_HORIZ_DIVISOR, hd);
    write_reg(REG_VERT_DIVISOR, vd);
  endtask

  function automatic bit [6:0] pick_divisor();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 7'd0;
    if (r == 1) return 7'($urandom_range(127, 65));
    return 7'($urandom_range(64, 1));
  endfunction

  task automatic random_poll();
    logic signed [7:0] ldx;
    logic signed [7:0] ldy;
    logic signed [6:0] rdx;
    logic signed [6:0] rdy;
    int                kind;
    kind = $urandom_range(9);
    if (kind < 3) begin
      ldx = 8'($urandom_range(4) - 2);
      ldy = 8'($urandom_range(4) - 2);
    end else if (kind < 6) begin
      ldx = 8'($urandom_range(40) - 20);
      ldy = 8'($urandom_range(40) - 20);
    end else begin
      ldx = 8'($urandom);
      ldy = 8'($urandom);
    end
    kind = $urandom_range(9);
    if (kind == 0) begin
      rdx = '0;
      rdy = '0;
    end else if (kind < 3) begin
      rdx = 7'($urandom);
      rdy = 7'($urandom);
    end else if (kind < 6) begin
      rdx = 7'($urandom_range(10) - 5);
      rdy = 7'($urandom_range(10) - 5);
    end else begin
      rdx = 7'($urandom_range(85) - 43);
      rdy = 7'($urandom_range(85) - 43);
    end
    send_poll(ldx, ldy, rdx, rdy);
  endtask

  initial begin
    board = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // gain thresholds, local and remote cursor sources
    apply_setting(1'b1, 3'd5, 3'd7, 1'b0, 1'b0, 7'd10, 7'd20);
    send_poll(8'sd3, -8'sd3, 7'sd0, 7'sd0);
    send_poll(8'sd12, -8'sd12, 7'sd0, 7'sd0);
    send_poll(8'sd15, -8'sd15, 7'sd0, 7'sd0);
    send_poll(8'sd127, -8'sd128, 7'sd1, 7'sd1);
    send_poll(8'sd0, 8'sd0, -7'sd64, 7'sd63);
    send_poll(8'sd2, -8'sd2, 7'sd1, -7'sd4);
    send_poll(8'sd0, 8'sd0, 7'sd5, -7'sd5);

    // remote half
    settle();
    write_reg(REG_IS_MAIN_HALF, 7'd0);
    send_poll(-8'sd128, 8'sd127, 7'sd63, -7'sd64);
    send_poll(-8'sd2, 8'sd5, 7'sd0, 7'sd0);

    // gain zero, divisor zero
    settle();
    apply_setting(1'b1, 3'd0, 3'd0, 1'b1, 1'b0, 7'd0, 7'd0);
    send_poll(-8'sd128, 8'sd127, 7'sd42, -7'sd43);
    send_poll(8'sd9, -8'sd9, 7'sd3, 7'sd3);

    // accumulator wrap, then a full-scale quotient after the divisor drops to one
    settle();
    apply_setting(1'b1, 3'd2, 3'd2, 1'b1, 1'b1, 7'd127, 7'd127);
    send_poll(8'sd0, 8'sd0, -7'sd64, 7'sd63);
    send_poll(8'sd0, 8'sd0, -7'sd36, 7'sd63);
    send_poll(8'sd0, 8'sd0, 7'sd0, 7'sd63);
    settle();
    write_reg(REG_HORIZ_DIVISOR, 7'd1);
    send_poll(8'sd0, 8'sd0, -7'sd28, 7'sd0);

    for (int ph = 0; ph < 14; ph++) begin
      settle();
      case (ph)
        0: apply_setting(1'b1, 3'd1, 3'd6, 1'b0, 1'b0, 7'd1, 7'd64);
        1: apply_setting(1'b1, 3'd6, 3'd1, 1'b1, 1'b1, 7'd1, 7'd1);
        2: apply_setting(1'b1, 3'd3, 3'd7, 1'b0, 1'b1, 7'd64, 7'd64);
        3: apply_setting(1'b1, 3'd0, 3'd2, 1'b1, 1'b0, 7'd0, 7'd127);
        4: apply_setting(1'b0, 3'd4, 3'd4, 1'b1, 1'b1, 7'd10, 7'd20);
        5: apply_setting(1'b1, 3'd7, 3'd3, 1'b1, 1'b1, 7'd3, 7'd7);
        default: apply_setting($urandom_range(99) < 85, 3'($urandom_range(7)),
                               3'($urandom_range(7)), 1'($urandom_range(1)),
                               1'($urandom_range(1)), pick_divisor(), pick_divisor());
      endcase
      in_idle_pct  = (ph == 7) ? 0 : 14;
      out_idle_pct = (ph == 7) ? 0 : 14;
      repeat (104) random_poll();
    end

    settle();
    repeat (30) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
hdl/spmm_pkg.sv
hdl/spmm_div.sv
hdl/spmm_ctrl.sv
hdl/spmm_dp.sv
hdl/split_pointer_motion_mixer_top.sv
tb/tb_split_pointer_motion_mixer_top.sv
